FILE: rtl/core/coin_hopper_pulse_controller_top_assert.svh
// Assertion macros used by the checker file.
// Each macro takes a label, clock, active-low reset, antecedent, consequent
// and a message string.
`ifndef COIN_HOPPER_PULSE_CONTROLLER_TOP_ASSERT_SVH
`define COIN_HOPPER_PULSE_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication.
`define CHPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/chpc_pkg.sv
`timescale 1ns / 1ps

package chpc_pkg;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_STOP  = 2'd2,
        KIND_RESET = 2'd3
    } chpc_kind_t;

    // Config register indexes
    typedef enum logic [1:0] {
        CFG_PULSE_MS   = 2'd0,
        CFG_COOL_MS    = 2'd1,
        CFG_MAX_GAP_MS = 2'd2,
        CFG_ACTIVE_LOW = 2'd3
    } chpc_cfg_idx_t;

    localparam logic [15:0] PULSE_MS_RST   = 16'd200;
    localparam logic [15:0] COOL_MS_RST    = 16'd300;
    localparam logic [15:0] MAX_GAP_MS_RST = 16'd3000;
    localparam logic        ACTIVE_LOW_RST = 1'b0;

    localparam logic [15:0] COIN_QUIET_MS = 16'd50;
    localparam logic [15:0] PUSH_BLANK_MS = 16'd150;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    typedef struct packed {
        logic [15:0] pulse_ms;
        logic [15:0] cool_ms;
        logic [15:0] max_gap_ms;
        logic        active_low;
    } chpc_cfg_t;

    typedef struct packed {
        chpc_kind_t  kind;
        logic        sensor_event;
        logic [15:0] target_count;
    } chpc_item_t;

    // Packed LSB-last: drive_level ends up in bit 0
    typedef struct packed {
        logic        start_ok;
        logic        timeout_pulse;
        logic        done_pulse;
        logic [15:0] paid_out;
        logic        busy_out;
        logic        drive_level;
    } chpc_result_t;

    localparam int RESULT_W = $bits(chpc_result_t);

endpackage

FILE: rtl/core/chpc_in_reg.sv
`timescale 1ns / 1ps

module chpc_in_reg
    import chpc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  chpc_item_t s_item,
    input  logic       adv,      // downstream takes the held item this cycle
    output logic       valid,
    output chpc_item_t item
);

    logic       valid_reg;
    chpc_item_t item_reg;

    assign s_ready = !valid_reg || adv;
    assign valid   = valid_reg;
    assign item    = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

FILE: rtl/core/chpc_step.sv
`timescale 1ns / 1ps

module chpc_step
    import chpc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         fire,
    input  chpc_item_t   item,
    input  chpc_cfg_t    cfg,
    output chpc_result_t result
);

    logic        busy_reg, busy_next;
    logic        pulsing_reg, pulsing_next;
    logic [15:0] target_reg, target_next;
    logic [15:0] paid_reg, paid_next;
    logic [15:0] push_reg, push_next;
    logic [15:0] cool_reg, cool_next;
    logic [15:0] coin_reg, coin_next;
    logic        prev_reg, prev_next;

    logic        done, timeout, start_ok;
    logic [15:0] push_inc, cool_inc, coin_inc;
    logic        coin_edge;

    // saturating elapsed counters
    assign push_inc = (push_reg == 16'hFFFF) ? push_reg : push_reg + 16'd1;
    assign cool_inc = (cool_reg == 16'hFFFF) ? cool_reg : cool_reg + 16'd1;
    assign coin_inc = (coin_reg == 16'hFFFF) ? coin_reg : coin_reg + 16'd1;

    always_comb begin
        busy_next    = busy_reg;
        pulsing_next = pulsing_reg;
        target_next  = target_reg;
        paid_next    = paid_reg;
        push_next    = push_reg;
        cool_next    = cool_reg;
        coin_next    = coin_reg;
        prev_next    = prev_reg;
        done         = 1'b0;
        timeout      = 1'b0;
        start_ok     = 1'b0;
        coin_edge    = 1'b0;

        unique case (item.kind)
            KIND_START: begin
                if (!busy_reg && item.target_count != 16'd0) begin
                    target_next  = item.target_count;
                    paid_next    = 16'd0;
                    busy_next    = 1'b1;
                    coin_next    = 16'd0;
                    pulsing_next = 1'b1;
                    push_next    = 16'd0;
                    start_ok     = 1'b1;
                end
            end
            KIND_STOP: begin
                busy_next    = 1'b0;
                pulsing_next = 1'b0;
            end
            KIND_RESET: begin
                busy_next    = 1'b0;
                pulsing_next = 1'b0;
                paid_next    = 16'd0;
                target_next  = 16'd0;
                push_next    = 16'd0;
                cool_next    = 16'd0;
                coin_next    = 16'd0;
            end
            KIND_TICK: begin
                if (busy_reg) begin
                    push_next = push_inc;
                    cool_next = cool_inc;
                    coin_next = coin_inc;

                    // push timing: end of push, or new push after the off gap and coin quiet time
                    if (pulsing_reg) begin
                        if (push_inc >= cfg.pulse_ms) begin
                            pulsing_next = 1'b0;
                            cool_next    = 16'd0;
                        end
                    end else if (cool_inc >= cfg.cool_ms && coin_inc >= COIN_QUIET_MS) begin
                        pulsing_next = 1'b1;
                        push_next    = 16'd0;
                    end

                    // coin counted on a rising sensor event, blanked early in a push
                    coin_edge = item.sensor_event && !prev_reg && (push_next > PUSH_BLANK_MS);
                    if (coin_edge) begin
                        if (paid_reg != 16'hFFFF) begin
                            paid_next = paid_reg + 16'd1;
                        end
                        coin_next = 16'd0;
                        if (target_reg != 16'd0 && paid_next >= target_reg) begin
                            busy_next    = 1'b0;
                            pulsing_next = 1'b0;
                            done         = 1'b1;
                        end
                    end
                    prev_next = item.sensor_event;

                    if (busy_next && coin_next >= cfg.max_gap_ms) begin
                        busy_next    = 1'b0;
                        pulsing_next = 1'b0;
                        timeout      = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pulsing_reg <= 1'b0;
            target_reg  <= 16'd0;
            paid_reg    <= 16'd0;
            push_reg    <= 16'd0;
            cool_reg    <= 16'd0;
            coin_reg    <= 16'd0;
            prev_reg    <= 1'b0;
        end else if (fire) begin
            busy_reg    <= busy_next;
            pulsing_reg <= pulsing_next;
            target_reg  <= target_next;
            paid_reg    <= paid_next;
            push_reg    <= push_next;
            cool_reg    <= cool_next;
            coin_reg    <= coin_next;
            prev_reg    <= prev_next;
        end
    end

    always_comb begin
        result.drive_level   = pulsing_next ^ cfg.active_low;
        result.busy_out      = busy_next;
        result.paid_out      = paid_next;
        result.done_pulse    = done;
        result.timeout_pulse = timeout;
        result.start_ok      = start_ok;
    end

endmodule

FILE: rtl/core/chpc_out_reg.sv
`timescale 1ns / 1ps

module chpc_out_reg
    import chpc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  chpc_result_t result,
    output logic         room,     // can take a result this cycle
    output logic         m_valid,
    input  logic         m_ready,
    output chpc_result_t m_result
);

    logic         valid_reg;
    chpc_result_t result_reg;

    assign room     = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (room) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

FILE: rtl/core/coin_hopper_pulse_controller_top.sv
`timescale 1ns / 1ps

// Coin hopper payout controller. Each item on the s_ stream is a command
// (tick of one millisecond, start, stop, reset); each one gives exactly one
// result item on the m_ stream with the actuator pin level, busy flag, coin
// count and done/timeout/start-accepted flags. Throughput is one item per
// clock while m_tready is high. An accepted item is held in the input
// register, and the updated state is loaded into the result register when
// that register has room. The rate is set by the update of the payout
// state, which every item reads and writes. Config registers are written
// through cfg_we / cfg_index / cfg_wdata and should change only while no
// item is in flight.
module coin_hopper_pulse_controller_top
    import chpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [15:0] target_count, [16] sensor_event, [23:17] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] kind
    input  logic [1:0]           s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] drive_level, [1] busy_out, [17:2] paid_out, [18] done_pulse,
    // [19] timeout_pulse, [20] start_ok, [23:21] zero
    output logic [M_TDATA_W-1:0] m_tdata,

    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_wdata
);

    chpc_cfg_t    cfg_reg;
    chpc_item_t   s_item;
    chpc_item_t   held_item;
    chpc_result_t step_result;
    chpc_result_t m_result;
    logic         held_valid;
    logic         out_room;
    logic         fire;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_ms   <= PULSE_MS_RST;
            cfg_reg.cool_ms    <= COOL_MS_RST;
            cfg_reg.max_gap_ms <= MAX_GAP_MS_RST;
            cfg_reg.active_low <= ACTIVE_LOW_RST;
        end else if (cfg_we) begin
            unique case (chpc_cfg_idx_t'(cfg_index))
                CFG_PULSE_MS:   cfg_reg.pulse_ms   <= cfg_wdata;
                CFG_COOL_MS:    cfg_reg.cool_ms    <= cfg_wdata;
                CFG_MAX_GAP_MS: cfg_reg.max_gap_ms <= cfg_wdata;
                CFG_ACTIVE_LOW: cfg_reg.active_low <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        s_item.kind         = chpc_kind_t'(s_tuser);
        s_item.sensor_event = s_tdata[16];
        s_item.target_count = s_tdata[15:0];
    end

    // held item is processed when the result register has room
    assign fire = held_valid && out_room;

    chpc_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .adv     (out_room),
        .valid   (held_valid),
        .item    (held_item)
    );

    chpc_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (held_item),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    chpc_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result   (step_result),
        .room     (out_room),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {(M_TDATA_W - RESULT_W)'(0), m_result};

endmodule

FILE: rtl/core/chpc_checker.sv
`timescale 1ns / 1ps

`include "coin_hopper_pulse_controller_top_assert.svh"

module chpc_checker
    import chpc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    chpc_result_t res;

    assign res = chpc_result_t'(m_tdata[RESULT_W-1:0]);

    // stalled result holds
    `CHPC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // a payout cannot both finish and time out
    `CHPC_ASSERT_NOW(a_end_excl, aclk, aresetn, m_tvalid, !(res.done_pulse && res.timeout_pulse), "done and timeout together")

    // accepted start: busy, count cleared, done/timeout quiet
    `CHPC_ASSERT_NOW(a_start, aclk, aresetn, m_tvalid && res.start_ok, res.busy_out && res.paid_out == 16'd0 && !res.done_pulse && !res.timeout_pulse, "bad start result")

    // end of payout leaves the block idle
    `CHPC_ASSERT_NOW(a_end_idle, aclk, aresetn, m_tvalid && (res.done_pulse || res.timeout_pulse), !res.busy_out, "busy after payout end")

endmodule

bind coin_hopper_pulse_controller_top chpc_checker u_chpc_checker (.*);
